[src/pcide_pkg.sv]
// Package with the shared types, offsets and reset image of the IDE configuration space.
package pcide_pkg;

    // Access kind carried by a request.
    typedef enum logic {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } op_t;

    // Controller states.
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic commit;
        logic load_out;
    } pcide_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_read;
    } pcide_status_t;

    localparam int unsigned SPACE_DEPTH = 256;
    localparam int unsigned OFF_W       = $clog2(SPACE_DEPTH);

    // Offsets with special write or read behavior.
    localparam logic [7:0] OFF_COMMAND    = 8'h04;
    localparam logic [7:0] OFF_COMMAND_HI = 8'h05;
    localparam logic [7:0] OFF_STATUS_HI  = 8'h07;
    localparam logic [7:0] OFF_BAR0       = 8'h10;
    localparam logic [7:0] OFF_BAR1       = 8'h14;
    localparam logic [7:0] OFF_BAR2       = 8'h18;
    localparam logic [7:0] OFF_BAR3       = 8'h1c;
    localparam logic [7:0] OFF_BAR4       = 8'h20;
    localparam logic [7:0] OFF_SUBSYS_LO  = 8'h2e;
    localparam logic [7:0] OFF_SUBSYS_HI  = 8'h2f;
    localparam logic [7:0] OFF_ROM0       = 8'h30;
    localparam logic [7:0] OFF_ROM1       = 8'h31;
    localparam logic [7:0] OFF_ROM2       = 8'h32;
    localparam logic [7:0] OFF_ROM3       = 8'h33;
    localparam logic [7:0] OFF_MISC       = 8'h51;
    localparam logic [7:0] OFF_UNLOCK     = 8'h5a;
    localparam logic [7:0] OFF_DPLL       = 8'h5b;
    localparam logic [7:0] OFF_CLK_LO     = 8'h78;
    localparam logic [7:0] OFF_CLK_HI     = 8'h79;

    // Write masks.
    localparam logic [7:0] MASK_COMMAND    = 8'h07;
    localparam logic [7:0] MASK_COMMAND_HI = 8'h01;
    localparam logic [7:0] MASK_STATUS_W1C = 8'hb8;
    localparam logic [7:0] MASK_BAR_IO8    = 8'hf8;
    localparam logic [7:0] MASK_BAR_IO4    = 8'hfc;
    localparam logic [7:0] MASK_BAR_IO16   = 8'hf0;
    localparam logic [7:0] MASK_MISC       = 8'hf0;
    localparam logic [7:0] MASK_DPLL       = 8'h7f;

    localparam logic [6:0] DPLL_SLOW_CODE  = 7'h28;
    localparam logic [7:0] DPLL_RESET      = 8'h23;
    localparam int unsigned UNLOCK_BIT     = 2;
    localparam logic [7:0] FN1_READ        = 8'hff;

    // ROM BAR alignment masks for the two window sizes.
    localparam logic [31:0] ROM_WIN_SMALL  = 32'h0000_8000;
    localparam logic [31:0] ROM_WIN_BIG    = 32'h0001_0000;
    localparam logic [31:0] ROM_MASK_SMALL = ~(ROM_WIN_SMALL - 32'd1);
    localparam logic [31:0] ROM_MASK_BIG   = ~(ROM_WIN_BIG - 32'd1);

    // Power-on contents of function 0; bytes not listed are zero.
    function automatic logic [7:0] pcide_image(input logic [7:0] off);
        logic [7:0] v;
        v = 8'h00;
        case (off)
            8'h00: v = 8'h03;
            8'h01: v = 8'h11;
            8'h02: v = 8'h04;
            8'h06: v = 8'h10;
            8'h07: v = 8'h02;
            8'h08: v = 8'h03;
            8'h0a: v = 8'h04;
            8'h0b: v = 8'h01;
            8'h10: v = 8'h01;
            8'h14: v = 8'h01;
            8'h18: v = 8'h01;
            8'h1c: v = 8'h01;
            8'h20: v = 8'h01;
            8'h2c: v = 8'h03;
            8'h2d: v = 8'h11;
            8'h2e: v = 8'h04;
            8'h34: v = 8'h60;
            8'h3d: v = 8'h01;
            8'h40: v = 8'ha7;
            8'h41: v = 8'ha7;
            8'h42: v = 8'h20;
            8'h43: v = 8'h01;
            8'h44: v = 8'ha7;
            8'h45: v = 8'ha7;
            8'h46: v = 8'h20;
            8'h47: v = 8'h01;
            8'h50: v = 8'h04;
            8'h54: v = 8'h04;
            8'h5b: v = DPLL_RESET;
            8'h60: v = 8'h01;
            8'h78: v = 8'h9c;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

[src/pcide_ctrl.sv]
// Controller state machine that sequences each configuration request.
module pcide_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    output logic                    m_valid,
    input  logic                    m_ready,
    input  pcide_pkg::pcide_status_t status,
    output pcide_pkg::pcide_cmd_t    cmd
);
    import pcide_pkg::*;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;

    // Next state: a write finishes at once, a read waits for a free output register.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_EXEC;
            end
            ST_EXEC: begin
                if (!status.is_read || out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs and commands to the datapath; no request is taken while reset is held.
    always_comb begin
        cmd          = '0;
        s_ready      = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                s_ready     = aresetn;
                cmd.capture = s_valid && aresetn;
            end
            ST_EXEC: begin
                cmd.commit   = !status.is_read || out_free;
                cmd.load_out = status.is_read && out_free;
                if (cmd.load_out) m_valid_next = 1'b1;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

[src/pcide_datapath.sv]
// Datapath with the configuration byte memory, special registers and write masks.
module pcide_datapath (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  pcide_pkg::pcide_cmd_t    cmd,
    output pcide_pkg::pcide_status_t status,
    input  logic                     cfg_we,
    input  logic                     cfg_data,
    input  logic                     s_operation,
    input  logic                     s_function_number,
    input  logic [7:0]               s_register_offset,
    input  logic [7:0]               s_write_byte,
    output logic [7:0]               m_read_byte
);
    import pcide_pkg::*;

    // Captured request.
    logic             op_reg;
    logic             fn_reg;
    logic [OFF_W-1:0] off_reg;
    logic [7:0]       data_reg;

    // Function 0 byte memory with a valid bit for each entry.
    logic [7:0]             mem_reg [SPACE_DEPTH];
    logic [7:0]             rd_reg;
    logic [SPACE_DEPTH-1:0] valid_reg, valid_next;

    // Bytes kept outside the memory because other logic reads them directly.
    logic [31:0] rombar_reg, rombar_next;
    logic [7:0]  unlock_reg, unlock_next;
    logic [7:0]  dpll_reg, dpll_next;
    logic [3:0]  dpll_cnt_reg, dpll_cnt_next;
    logic        rom_large_reg;
    logic [7:0]  out_reg;

    logic        wr_commit;
    logic        rd_commit;
    logic [7:0]  cur_byte;
    logic [7:0]  dpll_view;
    logic        dpll_slow;
    logic [7:0]  rd_val;
    logic        mem_we;
    logic [7:0]  mem_wdata;
    logic [31:0] bar_w;

    assign status.is_read = (op_reg == OP_READ);
    assign wr_commit = cmd.commit && (op_reg == OP_WRITE) && !fn_reg;
    assign rd_commit = cmd.commit && (op_reg == OP_READ) && !fn_reg;

    // Memory contents, or the power-on value where the entry was never written.
    assign cur_byte = valid_reg[off_reg] ? rd_reg : pcide_image(off_reg);

    // DPLL view: the lock bit follows the read counter in the slow setting.
    assign dpll_slow = (dpll_reg[6:0] == DPLL_SLOW_CODE);
    assign dpll_view = {dpll_slow ? dpll_cnt_reg[3] : 1'b1, dpll_reg[6:0]};

    // Read data selection.
    always_comb begin
        case (off_reg)
            OFF_ROM0:   rd_val = rombar_reg[7:0];
            OFF_ROM1:   rd_val = rombar_reg[15:8];
            OFF_ROM2:   rd_val = rombar_reg[23:16];
            OFF_ROM3:   rd_val = rombar_reg[31:24];
            OFF_UNLOCK: rd_val = unlock_reg;
            OFF_DPLL:   rd_val = dpll_view;
            default:    rd_val = cur_byte;
        endcase
    end

    // ROM BAR with the written byte merged in, before alignment.
    always_comb begin
        bar_w = rombar_reg;
        case (off_reg[1:0])
            2'd0:    bar_w[7:0]   = data_reg;
            2'd1:    bar_w[15:8]  = data_reg;
            2'd2:    bar_w[23:16] = data_reg;
            default: bar_w[31:24] = data_reg;
        endcase
    end

    // Write decode with the per-offset masks.
    always_comb begin
        mem_we        = 1'b0;
        mem_wdata     = data_reg;
        rombar_next   = rombar_reg;
        unlock_next   = unlock_reg;
        dpll_next     = dpll_reg;
        dpll_cnt_next = dpll_cnt_reg;
        case (off_reg)
            OFF_COMMAND: begin
                mem_we    = 1'b1;
                mem_wdata = data_reg & MASK_COMMAND;
            end
            OFF_COMMAND_HI: begin
                mem_we    = 1'b1;
                mem_wdata = data_reg & MASK_COMMAND_HI;
            end
            OFF_STATUS_HI: begin
                mem_we    = 1'b1;
                mem_wdata = cur_byte & ~(data_reg & MASK_STATUS_W1C);
            end
            OFF_BAR0, OFF_BAR2: begin
                mem_we    = 1'b1;
                mem_wdata = (data_reg & MASK_BAR_IO8) | 8'h01;
            end
            OFF_BAR1, OFF_BAR3: begin
                mem_we    = 1'b1;
                mem_wdata = (data_reg & MASK_BAR_IO4) | 8'h01;
            end
            OFF_BAR4: begin
                mem_we    = 1'b1;
                mem_wdata = (data_reg & MASK_BAR_IO16) | 8'h01;
            end
            OFF_SUBSYS_LO, OFF_SUBSYS_HI: begin
                mem_we = unlock_reg[UNLOCK_BIT];
            end
            OFF_ROM0, OFF_ROM1, OFF_ROM2, OFF_ROM3: begin
                rombar_next = (bar_w & (rom_large_reg ? ROM_MASK_BIG : ROM_MASK_SMALL))
                              | {31'd0, bar_w[0]};
            end
            OFF_MISC: begin
                mem_we    = 1'b1;
                mem_wdata = data_reg & MASK_MISC;
            end
            OFF_UNLOCK: begin
                unlock_next = data_reg;
            end
            OFF_DPLL: begin
                dpll_next     = data_reg & MASK_DPLL;
                dpll_cnt_next = 4'd0;
            end
            OFF_CLK_LO, OFF_CLK_HI: begin
                mem_we = 1'b0;
            end
            default: begin
                mem_we = off_reg inside {8'h0d, [8'h11:8'h13], [8'h15:8'h17],
                                         [8'h19:8'h1b], [8'h1d:8'h1f], [8'h21:8'h23],
                                         8'h3c, [8'h40:8'h50], [8'h52:8'h59],
                                         [8'h5c:8'h77], [8'h7a:8'hff]};
            end
        endcase
    end

    // Valid bit set on every memory write.
    always_comb begin
        valid_next = valid_reg;
        if (wr_commit && mem_we) valid_next[off_reg] = 1'b1;
    end

    // Request capture, memory port and output register.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg   <= s_operation;
            fn_reg   <= s_function_number;
            off_reg  <= s_register_offset;
            data_reg <= s_write_byte;
            rd_reg   <= mem_reg[s_register_offset];
        end
        if (wr_commit && mem_we) mem_reg[off_reg] <= mem_wdata;
        if (cmd.load_out) out_reg <= fn_reg ? FN1_READ : rd_val;
    end

    // Control state and special registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            rombar_reg    <= 32'd0;
            unlock_reg    <= 8'h00;
            dpll_reg      <= DPLL_RESET;
            dpll_cnt_reg  <= 4'd0;
            rom_large_reg <= 1'b0;
        end else begin
            if (cfg_we) rom_large_reg <= cfg_data;
            if (wr_commit) begin
                valid_reg    <= valid_next;
                rombar_reg   <= rombar_next;
                unlock_reg   <= unlock_next;
                dpll_reg     <= dpll_next;
                dpll_cnt_reg <= dpll_cnt_next;
            end else if (rd_commit && (off_reg == OFF_DPLL) && dpll_slow) begin
                dpll_cnt_reg <= dpll_cnt_reg + 4'd1;
            end
        end
    end

    assign m_read_byte = out_reg;

endmodule

[src/pci_ide_config_space.sv]
// Top level of the IDE controller configuration space: controller plus datapath.
//
// Usage:
//   Requests arrive on the s_ channel (s_valid/s_ready) as one byte access each:
//   s_operation selects read or write, s_function_number the PCI function,
//   s_register_offset the byte and s_write_byte the data of a write.
//   Each read returns one byte on the m_ channel (m_valid/m_ready); a write
//   returns nothing. The ROM window size is written on the cfg_ channel,
//   which is ready whenever reset is released; the user must write it only
//   while no request is in flight, as the block itself does not enforce this.
//   Each request is first captured while the byte memory is read, then the
//   write masks are applied or the read data is selected. The read port of
//   the byte memory is registered. A read result is loaded into the output
//   register in the execute state, once the output register is free.
//   The output register lets the next request be accepted while a result
//   waits; a read finding the output register still full holds until the
//   receiver takes the older result.
//   Reset returns function 0 to its power-on image at once through per-byte
//   valid bits; no clearing pass is needed.
module pci_ide_config_space (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_operation,
    input  logic       s_function_number,
    input  logic [7:0] s_register_offset,
    input  logic [7:0] s_write_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_read_byte
);
    import pcide_pkg::*;

    pcide_cmd_t    cmd;
    pcide_status_t status;

    assign cfg_ready = aresetn;

    // Sequencing of each request.
    pcide_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Storage and masking of the configuration bytes.
    pcide_datapath u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .status            (status),
        .cfg_we            (cfg_valid && cfg_ready),
        .cfg_data          (cfg_data),
        .s_operation       (s_operation),
        .s_function_number (s_function_number),
        .s_register_offset (s_register_offset),
        .s_write_byte      (s_write_byte),
        .m_read_byte       (m_read_byte)
    );

    // After a request is accepted, s_ready stays low while the block executes it.
    a_two_cycles: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted in back-to-back cycles");

    // A result is only loaded while a request is being executed.
    a_result_from_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared without a request in execution");

    // A write produces no result.
    a_write_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_operation == OP_WRITE) && !m_valid)
        |=> !m_valid ##1 !m_valid)
        else $error("write request produced a result");

    // The datapath never commits and captures in the same cycle.
    a_cmd_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.capture && cmd.commit))
        else $error("capture and commit issued together");

endmodule
